[design/mtf_pkg.sv]
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants of the move-to-front history list.
// ----------------------------------------------------------------------------
`default_nettype none

package mtf_pkg;

    // fixed field widths on the channels and of the capacity register
    localparam int KEY_FIELD_W = 16;
    localparam int POS_W       = 4;
    localparam int OCC_W       = 5;
    localparam int CAP_W       = 5;

    // defaults of the top-level parameters
    localparam int DEF_LIST_DEPTH = 16;
    localparam int DEF_KEY_BITS   = 16;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0]     CAPACITY_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

[design/mtf_if.sv]
// ----------------------------------------------------------------------------
// mtf_if
// Valid/ready channels: access key in, access report out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtf_in_if;
    logic                               valid;
    logic                               ready;
    logic [mtf_pkg::KEY_FIELD_W-1:0]    contact_key;

    modport source (output valid, output contact_key, input ready);
    modport sink   (input valid, input contact_key, output ready);
endinterface

interface mtf_out_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [mtf_pkg::POS_W-1:0]          hit_position;
    logic                               evicted;
    logic [mtf_pkg::KEY_FIELD_W-1:0]    evicted_key;
    logic [mtf_pkg::OCC_W-1:0]          occupancy;

    modport source (output valid, output hit, output hit_position, output evicted,
                    output evicted_key, output occupancy, input ready);
    modport sink   (input valid, input hit, input hit_position, input evicted,
                    input evicted_key, input occupancy, output ready);
endinterface

`default_nettype wire

[design/move_to_front_history_list_unit.sv]
// ----------------------------------------------------------------------------
// move_to_front_history_list_unit
// Recency-ordered key list with move-to-front on hit, insert on miss.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one contact key per word; o_out returns one report per
//   access: hit, former position, eviction, evicted key and occupancy.
//   The APB port holds the capacity register at byte address 0.
//   The keys sit in one synchronous RAM. A single pass walks the list from
//   the front: each cycle it reads entry i+1 while writing entry i with the
//   key carried from entry i-1, so scan and shift happen together. The pass
//   ends on a match or at the tail.
//   A hit stops the walk at the matching position, a miss walks all keys
//   held; the report then loads from the finish state. One access is in
//   flight at a time: the next key is accepted once the report is loaded,
//   and the RAM walk covers one entry per cycle.
//   A finished report waits in the output register; if the receiver stalls
//   with a report still pending, the next access holds before finishing.
//   Reset empties the list (count zero, RAM contents left as they are)
//   and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_front_history_list_unit #(
    parameter int LIST_DEPTH = mtf_pkg::DEF_LIST_DEPTH,
    parameter int KEY_BITS   = mtf_pkg::DEF_KEY_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    mtf_in_if.sink                                  i_in,
    mtf_out_if.source                               o_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mtf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [mtf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [mtf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > mtf_pkg::CAP_W) ? CW : mtf_pkg::CAP_W;

    // ---------------- configuration ----------------
    logic [mtf_pkg::CAP_W-1:0] r_capacity;
    logic                      cfg_wr;
    logic                      cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[mtf_pkg::APB_ADDR_W-1:2] == mtf_pkg::REG_CAPACITY);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? mtf_pkg::APB_DATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= mtf_pkg::CAPACITY_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[mtf_pkg::CAP_W-1:0];
        end
    end

    // zero counts as one, above the depth clamps to the depth
    logic [CW-1:0] cap_eff;
    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = CW'(1);
        end else if (CMPW'(r_capacity) > CMPW'(LIST_DEPTH)) begin
            cap_eff = CW'(LIST_DEPTH);
        end else begin
            cap_eff = CW'(r_capacity);
        end
    end

    // ---------------- key RAM ----------------
    logic [KEY_BITS-1:0] r_order_keys [LIST_DEPTH];
    logic [KEY_BITS-1:0] r_rd_data;
    logic [IW-1:0]       mem_raddr;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [KEY_BITS-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_order_keys[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_order_keys[mem_raddr];
    end

    // ---------------- control ----------------
    mtf_pkg::t_state     r_state, n_state;
    logic [CW-1:0]       r_count;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_carry;
    logic [IW-1:0]       r_idx;
    logic                r_hit;
    logic [IW-1:0]       r_pos;
    logic                r_out_valid;

    logic [KEY_BITS-1:0] key_in;
    logic                in_fire;
    logic                out_load;
    logic                match;
    logic                at_tail;
    logic                at_cap;
    logic [CW-1:0]       new_count;

    assign key_in  = KEY_BITS'(i_in.contact_key);
    assign in_fire = i_in.valid && i_in.ready;
    assign match   = (r_rd_data == r_key);
    assign at_tail = ((CW'(r_idx) + CW'(1)) == r_count);
    assign at_cap  = (r_count >= cap_eff);

    always_comb begin
        if (r_hit) begin
            new_count = r_count;
        end else if (at_cap) begin
            new_count = cap_eff;
        end else begin
            new_count = r_count + CW'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = (r_count == '0) ? mtf_pkg::ST_FINISH : mtf_pkg::ST_SCAN;
                end
            end
            mtf_pkg::ST_SCAN: begin
                if (match || at_tail) begin
                    n_state = mtf_pkg::ST_FINISH;
                end
            end
            mtf_pkg::ST_FINISH: begin
                if (out_load) begin
                    n_state = mtf_pkg::ST_IDLE;
                end
            end
            default: n_state = mtf_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready = 1'b0;
        out_load   = 1'b0;
        mem_raddr  = '0;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = r_carry;
        unique case (r_state)
            mtf_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            mtf_pkg::ST_SCAN: begin
                // read ahead while the current entry takes the carried key
                mem_raddr = r_idx + IW'(1);
                mem_we    = 1'b1;
            end
            mtf_pkg::ST_FINISH: begin
                out_load  = !r_out_valid || o_out.ready;
                // miss: old tail moves one place down, if there is room
                mem_waddr = IW'(r_count);
                mem_we    = out_load && !r_hit && (r_count < CW'(LIST_DEPTH));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtf_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_count     <= new_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_key   <= key_in;
            r_carry <= key_in;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_pos   <= '0;
        end else if (r_state == mtf_pkg::ST_SCAN) begin
            r_carry <= r_rd_data;
            if (match) begin
                r_hit <= 1'b1;
                r_pos <= r_idx;
            end else begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    // ---------------- report register ----------------
    logic                              r_o_hit;
    logic [mtf_pkg::POS_W-1:0]         r_o_pos;
    logic                              r_o_evicted;
    logic [mtf_pkg::KEY_FIELD_W-1:0]   r_o_evicted_key;
    logic [mtf_pkg::OCC_W-1:0]         r_o_occupancy;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_hit         <= r_hit;
            r_o_pos         <= mtf_pkg::POS_W'(r_pos);
            r_o_evicted     <= !r_hit && at_cap;
            // carry holds the tail key once a miss has walked the list
            r_o_evicted_key <= (!r_hit && at_cap) ?
                               mtf_pkg::KEY_FIELD_W'(r_carry) : '0;
            r_o_occupancy   <= mtf_pkg::OCC_W'(new_count);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.hit          = r_o_hit;
    assign o_out.hit_position = r_o_pos;
    assign o_out.evicted      = r_o_evicted;
    assign o_out.evicted_key  = r_o_evicted_key;
    assign o_out.occupancy    = r_o_occupancy;

endmodule

`default_nettype wire
